// ----- sv/r30_pkg.sv -----
// r30_pkg: types, opcodes, status codes and constants for the radix-2^30 arithmetic unit
// used by every module of the unit; no dependencies
package r30_pkg;

  localparam int DIGIT_BITS_DEF = 30;
  localparam int NUM_W = 64;
  localparam int NUM_CELLS = NUM_W;

  typedef enum logic [1:0] {
    OP_MULMOD = 2'd0,
    OP_MULADD = 2'd1,
    OP_DIVREM = 2'd2,
    OP_SMOD   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_WIDEQ   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [31:0] operand_d;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] first_result;
    logic [33:0] second_result;
    logic [1:0]  status;
  } out_beat_t;

  // item travelling through the division cells
  typedef struct packed {
    logic        vld;
    logic [1:0]  opcode;
    logic        divzero;
    logic        neg_n;
    logic        neg_d;
    logic [63:0] n;
    logic [31:0] dv;
    logic [32:0] rem;
    logic [63:0] quo;
    logic [33:0] hi;
    logic [31:0] lo;
  } cell_t;

endpackage

// ----- sv/r30_front.sv -----
// r30_front: product stage and operand conditioning ahead of the division chain
// depends on r30_pkg
module r30_front #(
  parameter int DIGIT_BITS = r30_pkg::DIGIT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  r30_pkg::in_beat_t in_beat,
  output r30_pkg::cell_t  out_cell
);
  import r30_pkg::*;

  localparam logic [63:0] LOW_MASK = (64'd1 << DIGIT_BITS) - 64'd1;

  // stage 1: multiply
  logic        s1_vld;
  logic [1:0]  s1_op;
  logic [63:0] s1_prod;
  logic [31:0] s1_a, s1_b, s1_c, s1_d;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;

  always_comb begin
    if (in_beat.opcode == OP_SMOD) begin
      ma = {in_beat.operand_a[31], in_beat.operand_a};
      mb = {in_beat.operand_b[31], in_beat.operand_b};
    end else begin
      ma = {1'b0, in_beat.operand_a};
      mb = {1'b0, in_beat.operand_b};
    end
    mp = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
    if (en) begin
      s1_op   <= in_beat.opcode;
      s1_prod <= mp[63:0];
      s1_a    <= in_beat.operand_a;
      s1_b    <= in_beat.operand_b;
      s1_c    <= in_beat.operand_c;
      s1_d    <= in_beat.operand_d;
    end
  end

  // stage 2: add, take magnitudes
  cell_t       nxt;
  logic [63:0] sum_u, sum_s, nd, dabs;
  logic [33:0] hi_full;

  always_comb begin
    sum_u = s1_prod + {32'd0, s1_c};
    sum_s = s1_prod + {{32{s1_c[31]}}, s1_c};
    hi_full = 34'(sum_u >> DIGIT_BITS);
    dabs  = s1_d[31] ? (64'd0 - {{32{1'b1}}, s1_d}) : {32'd0, s1_d};
    nxt = '0;
    nxt.vld    = s1_vld;
    nxt.opcode = s1_op;
    nxt.hi     = hi_full;
    nxt.lo     = 32'(sum_u & LOW_MASK);
    nd = '0;
    unique case (opcode_t'(s1_op))
      OP_MULMOD: begin
        nd = s1_prod;
        nxt.dv = s1_c;
      end
      OP_MULADD: begin
        nd = '0;
        nxt.dv = 32'd1;
      end
      OP_DIVREM: begin
        nd = ({32'd0, s1_a} << DIGIT_BITS) + {32'd0, s1_b};
        nxt.dv = s1_c;
      end
      default: begin
        nxt.neg_n = sum_s[63];
        nxt.neg_d = s1_d[31];
        nd = sum_s[63] ? (64'd0 - sum_s) : sum_s;
        nxt.dv = dabs[31:0];
      end
    endcase
    nxt.n = nd;
    nxt.divzero = (s1_op != OP_MULADD) && (nxt.dv == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cell.vld <= 1'b0;
    end else if (en) begin
      out_cell.vld <= nxt.vld;
    end
    if (en) begin
      out_cell.opcode  <= nxt.opcode;
      out_cell.divzero <= nxt.divzero;
      out_cell.neg_n   <= nxt.neg_n;
      out_cell.neg_d   <= nxt.neg_d;
      out_cell.n       <= nxt.n;
      out_cell.dv      <= nxt.dv;
      out_cell.rem     <= nxt.rem;
      out_cell.quo     <= nxt.quo;
      out_cell.hi      <= nxt.hi;
      out_cell.lo      <= nxt.lo;
    end
  end

endmodule

// ----- sv/r30_cell.sv -----
// r30_cell: one restoring division step, one quotient bit per cell
// depends on r30_pkg
module r30_cell #(
  parameter int BIT_IDX = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  r30_pkg::cell_t in_cell,
  output r30_pkg::cell_t out_cell
);
  import r30_pkg::*;

  cell_t      nxt;
  logic [33:0] trial, diff;

  always_comb begin
    nxt   = in_cell;
    trial = {in_cell.rem, in_cell.n[BIT_IDX]};
    diff  = trial - {2'b00, in_cell.dv};
    if (!diff[33]) begin
      nxt.rem = diff[32:0];
      nxt.quo[BIT_IDX] = 1'b1;
    end else begin
      nxt.rem = trial[32:0];
      nxt.quo[BIT_IDX] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cell.vld <= 1'b0;
    end else if (en) begin
      out_cell.vld <= nxt.vld;
    end
    if (en) begin
      out_cell.opcode  <= nxt.opcode;
      out_cell.divzero <= nxt.divzero;
      out_cell.neg_n   <= nxt.neg_n;
      out_cell.neg_d   <= nxt.neg_d;
      out_cell.n       <= nxt.n;
      out_cell.dv      <= nxt.dv;
      out_cell.rem     <= nxt.rem;
      out_cell.quo     <= nxt.quo;
      out_cell.hi      <= nxt.hi;
      out_cell.lo      <= nxt.lo;
    end
  end

endmodule

// ----- sv/r30_back.sv -----
// r30_back: sign fix-up, status and result formatting after the division chain
// depends on r30_pkg
module r30_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  r30_pkg::cell_t     in_cell,
  output logic               out_vld,
  output r30_pkg::out_beat_t out_beat
);
  import r30_pkg::*;

  out_beat_t   nxt;
  logic [31:0] r_adj;
  logic        q_zero;
  logic        wide_s;

  always_comb begin
    q_zero = (in_cell.quo == 64'd0);
    // signed quotient magnitude is quo, sign neg_n ^ neg_d
    if (in_cell.neg_n ^ in_cell.neg_d) begin
      wide_s = (in_cell.quo > 64'h8000_0000) && !q_zero;
    end else begin
      wide_s = (in_cell.quo > 64'h7fff_ffff);
    end
    if (in_cell.neg_n && (in_cell.rem[31:0] != 32'd0)) begin
      r_adj = in_cell.dv - in_cell.rem[31:0];
    end else begin
      r_adj = in_cell.rem[31:0];
    end
    nxt = '0;
    if (in_cell.divzero) begin
      nxt.status = ST_DIVZERO;
    end else begin
      unique case (opcode_t'(in_cell.opcode))
        OP_MULMOD: begin
          nxt.first_result = in_cell.rem[31:0];
          nxt.status = (in_cell.quo[63:32] != 32'd0) ? ST_WIDEQ : ST_OK;
        end
        OP_MULADD: begin
          nxt.first_result  = in_cell.lo;
          nxt.second_result = in_cell.hi;
        end
        OP_DIVREM: begin
          nxt.first_result  = in_cell.quo[31:0];
          nxt.second_result = {2'b00, in_cell.rem[31:0]};
          nxt.status = (in_cell.quo[63:32] != 32'd0) ? ST_WIDEQ : ST_OK;
        end
        default: begin
          nxt.first_result = r_adj;
          nxt.status = wide_s ? ST_WIDEQ : ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_cell.vld;
    end
    if (en) begin
      out_beat <= nxt;
    end
  end

endmodule

// ----- sv/radix30_mulmod_divrem_unit_top.sv -----
// radix30_mulmod_divrem_unit_top: pipelined mulmod / multiply-add / divide-remainder / signed-mod unit
// depends on r30_pkg, r30_front, r30_cell, r30_back
//
//   channel | valid     | ready     | payload
//   in      | in_valid  | in_ready  | in_data  (r30_pkg::in_beat_t)
//   out     | out_valid | out_ready | out_data (r30_pkg::out_beat_t)
//
// one beat per cycle enters while the pipe is not held; the pipe has two front stages, one
// stage per quotient bit in a chain of 64 division cells, one result stage.
// the whole pipe advances together; it holds while the result stage is full
// and out_ready is low. reset empties the pipe and holds in_ready low.
module radix30_mulmod_divrem_unit_top #(
  parameter int DIGIT_BITS = r30_pkg::DIGIT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  r30_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output r30_pkg::out_beat_t out_data
);
  import r30_pkg::*;

  logic  en;
  cell_t chain [NUM_CELLS+1];

  assign en       = out_ready || !out_valid;
  assign in_ready = en && !rst;

  r30_front #(.DIGIT_BITS(DIGIT_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .in_beat  (in_data),
    .out_cell (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    r30_cell #(.BIT_IDX(NUM_W - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_cell  (chain[i]),
      .out_cell (chain[i+1])
    );
  end

  r30_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_cell  (chain[NUM_CELLS]),
    .out_vld  (out_valid),
    .out_beat (out_data)
  );

endmodule
